[sv/assert_macros.svh]
// Assertion macros shared by the checker files.
// Needs clk_i and rst_ni to be visible where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, ignored during reset
`define CSIM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csim checker: same-cycle check failed");

// Implication in the next cycle, ignored during reset
`define CSIM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csim checker: next-cycle check failed");

// Implication checked at every edge, reset included
`define CSIM_ASSERT_ALW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) (ante) |-> (cons)) \
    else $error("csim checker: check failed");

`endif

[sv/csim_pkg.sv]
// Shared constants, types and helpers for the cosine similarity engine.
// No dependencies.
package csim_pkg;

  localparam int unsigned MAX_ELEMENTS  = 65536;
  localparam int unsigned COUNT_BITS    = 16;
  localparam int unsigned FRACTION_BITS = 16;

  // fixed port widths
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned COS_W    = 17;

  localparam int unsigned SUM_W    = 48;
  localparam int unsigned PROD_W   = 2 * COUNT_BITS;
  localparam int unsigned TALLY_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned WIDE_W   = 2 * SUM_W;
  localparam int unsigned REM_W    = WIDE_W + 1;
  localparam int unsigned QUO_W    = 2 * FRACTION_BITS;
  localparam int unsigned ROOT_W   = FRACTION_BITS;
  localparam int unsigned SQR_W    = FRACTION_BITS + 2;
  localparam int unsigned RES_W    = FRACTION_BITS + 1;
  localparam int unsigned RESX_W   = (RES_W > COS_W) ? RES_W : COS_W;
  localparam int unsigned DIG_W    = 16;
  localparam int unsigned NDIG     = SUM_W / DIG_W;
  localparam int unsigned MPROD_W  = DIG_W + SUM_W;
  localparam int unsigned CNT_W    = $clog2(QUO_W + 1);
  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    sum_t dot;
    sum_t sq1;
    sum_t sq2;
    logic ovf;
  } csim_job_t;

  typedef struct packed {
    logic      valid;
    csim_job_t job;
  } csim_enq_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_D,
    ST_CMP,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } csim_state_e;

  // result register to the 17-bit port: high bits dropped for wide fractions
  function automatic logic [COS_W-1:0] res_to_port(input logic [RES_W-1:0] v);
    logic [RESX_W-1:0] wide;
    wide = RESX_W'(v);
    return wide[COS_W-1:0];
  endfunction

endpackage

[sv/csim_front.sv]
// Front end: takes element pairs, accumulates dot product and magnitudes.
// Depends on csim_pkg; hands finished sums to the job queue.
module csim_front import csim_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [COUNT_W-1:0] first_count_i,
  input  logic [COUNT_W-1:0] second_count_i,
  input  logic               last_element_i,
  output csim_enq_t          enq_o
);

  sum_t               dot_q, dot_d, sq1_q, sq1_d, sq2_q, sq2_d;
  logic [TALLY_W-1:0] tally_q, tally_d;
  logic               ovf_q, ovf_d;

  logic [COUNT_BITS-1:0] a, b;
  logic [PROD_W-1:0]     ab, aa, bb;
  logic                  at_limit;
  sum_t                  dot_n, sq1_n, sq2_n;
  logic                  ovf_n;

  function automatic sum_t sat_add(input sum_t s, input logic [PROD_W-1:0] v);
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W + 1)'(v);
    return t[SUM_W] ? '1 : t[SUM_W-1:0];
  endfunction

  assign a  = first_count_i[COUNT_BITS-1:0];
  assign b  = second_count_i[COUNT_BITS-1:0];
  assign ab = PROD_W'(a) * PROD_W'(b);
  assign aa = PROD_W'(a) * PROD_W'(a);
  assign bb = PROD_W'(b) * PROD_W'(b);

  assign at_limit = (tally_q >= TALLY_W'(MAX_ELEMENTS));

  always_comb begin
    dot_n = dot_q;
    sq1_n = sq1_q;
    sq2_n = sq2_q;
    ovf_n = ovf_q | at_limit;
    if (!at_limit) begin
      dot_n = sat_add(dot_q, ab);
      sq1_n = sat_add(sq1_q, aa);
      sq2_n = sat_add(sq2_q, bb);
    end
  end

  always_comb begin
    dot_d   = dot_q;
    sq1_d   = sq1_q;
    sq2_d   = sq2_q;
    tally_d = tally_q;
    ovf_d   = ovf_q;
    if (accept_i) begin
      if (last_element_i) begin
        dot_d   = '0;
        sq1_d   = '0;
        sq2_d   = '0;
        tally_d = '0;
        ovf_d   = 1'b0;
      end else begin
        dot_d   = dot_n;
        sq1_d   = sq1_n;
        sq2_d   = sq2_n;
        tally_d = at_limit ? tally_q : tally_q + TALLY_W'(1);
        ovf_d   = ovf_n;
      end
    end
  end

  assign enq_o.valid   = accept_i & last_element_i;
  assign enq_o.job.dot = dot_n;
  assign enq_o.job.sq1 = sq1_n;
  assign enq_o.job.sq2 = sq2_n;
  assign enq_o.job.ovf = ovf_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q   <= '0;
      sq1_q   <= '0;
      sq2_q   <= '0;
      tally_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      dot_q   <= dot_d;
      sq1_q   <= sq1_d;
      sq2_q   <= sq2_d;
      tally_q <= tally_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

[sv/csim_queue.sv]
// Short job queue between front and back end.
// Depends on csim_pkg.
module csim_queue import csim_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  csim_enq_t enq_i,
  output logic      full_o,
  output logic      deq_valid_o,
  output csim_job_t deq_job_o,
  input  logic      deq_ready_i
);

  csim_job_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_deq;

  assign full_o      = (cnt_q == QCNT_W'(QDEPTH));
  assign deq_valid_o = (cnt_q != '0);
  assign deq_job_o   = mem_q[rd_ptr_q];
  assign do_deq      = deq_valid_o & deq_ready_i;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_d = enq_i.valid ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_deq ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(enq_i.valid) - QCNT_W'(do_deq);
  end

  always_ff @(posedge clk_i) begin
    if (enq_i.valid) begin
      mem_q[wr_ptr_q] <= enq_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[sv/csim_back.sv]
// Back end: multi-cycle cosine unit (digit-serial multiply, restoring
// divide, bit-pair square root) and the result register. Depends on csim_pkg.
module csim_back import csim_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  csim_job_t        job_i,
  output logic             job_ready_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [COS_W-1:0] cosine_value_o,
  output logic             zero_magnitude_o,
  output logic             length_exceeded_o
);

  csim_state_e state_q, state_d;

  sum_t               dot_q, sq2_q, mplier_q, mcand;
  logic               zero_q, ovf_q;
  logic [WIDE_W-1:0]  acc_q, acc_d, p_q, rem_q;
  logic [MPROD_W-1:0] mprod;
  logic [QUO_W-1:0]   quo_q;
  logic [SQR_W-1:0]   sqrem_q, sq_in, trial;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic [RES_W-1:0]   res_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               cnt_last, job_zero, clamp;
  logic [REM_W-1:0]   rem_sh;
  logic               div_ge, sq_ge;

  logic               out_valid_q;
  logic [COS_W-1:0]   out_cos_q;
  logic               out_zero_q, out_ovf_q;

  // control strobes
  logic take_job, mul_run, div_run, sqrt_run, out_write;

  assign job_zero = (job_i.sq1 == '0) || (job_i.sq2 == '0);
  assign cnt_last = (cnt_q == CNT_W'(1));
  assign clamp    = (rem_q >= p_q);

  assign mcand = (state_q == ST_MUL_P) ? sq2_q : dot_q;
  assign mprod = MPROD_W'(mplier_q[SUM_W-1 -: DIG_W]) * MPROD_W'(mcand);
  assign acc_d = (acc_q << DIG_W) + WIDE_W'(mprod);

  assign rem_sh = {rem_q, 1'b0};
  assign div_ge = (rem_sh >= {1'b0, p_q});

  assign sq_in  = {sqrem_q[SQR_W-3:0], quo_q[QUO_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign sq_ge  = (sq_in >= trial);
  assign root_d = {root_q[ROOT_W-2:0], sq_ge};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (job_valid_i) state_d = job_zero ? ST_DONE : ST_MUL_P;
      ST_MUL_P: if (cnt_last) state_d = ST_MUL_D;
      ST_MUL_D: if (cnt_last) state_d = ST_CMP;
      ST_CMP:   state_d = clamp ? ST_DONE : ST_DIV;
      ST_DIV:   if (cnt_last) state_d = ST_SQRT;
      ST_SQRT:  if (cnt_last) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || pop_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // strobes
  always_comb begin
    take_job  = 1'b0;
    mul_run   = 1'b0;
    div_run   = 1'b0;
    sqrt_run  = 1'b0;
    out_write = 1'b0;
    unique case (state_q)
      ST_IDLE:  take_job  = job_valid_i;
      ST_MUL_P,
      ST_MUL_D: mul_run   = 1'b1;
      ST_CMP:   ;
      ST_DIV:   div_run   = 1'b1;
      ST_SQRT:  sqrt_run  = 1'b1;
      ST_DONE:  out_write = !out_valid_q || pop_i;
      default:  ;
    endcase
  end

  assign job_ready_o = (state_q == ST_IDLE);

  // datapath
  always_ff @(posedge clk_i) begin
    if (take_job) begin
      dot_q    <= job_i.dot;
      sq2_q    <= job_i.sq2;
      mplier_q <= job_i.sq1;
      zero_q   <= job_zero;
      ovf_q    <= job_i.ovf;
      acc_q    <= '0;
      res_q    <= '0;
      cnt_q    <= CNT_W'(NDIG);
    end
    if (mul_run) begin
      if (!cnt_last) begin
        mplier_q <= mplier_q << DIG_W;
        acc_q    <= acc_d;
        cnt_q    <= cnt_q - CNT_W'(1);
      end else if (state_q == ST_MUL_P) begin
        acc_q    <= '0;
        p_q      <= acc_d;
        mplier_q <= dot_q;
        cnt_q    <= CNT_W'(NDIG);
      end else begin
        acc_q <= '0;
        rem_q <= acc_d;
      end
    end
    if (state_q == ST_CMP) begin
      res_q <= {1'b1, ROOT_W'(0)};
      cnt_q <= CNT_W'(QUO_W);
    end
    if (div_run) begin
      rem_q <= WIDE_W'(div_ge ? rem_sh - {1'b0, p_q} : rem_sh);
      quo_q <= {quo_q[QUO_W-2:0], div_ge};
      if (cnt_last) begin
        cnt_q   <= CNT_W'(ROOT_W);
        sqrem_q <= '0;
        root_q  <= '0;
      end else begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
    if (sqrt_run) begin
      sqrem_q <= sq_ge ? sq_in - trial : sq_in;
      root_q  <= root_d;
      quo_q   <= quo_q << 2;
      cnt_q   <= cnt_q - CNT_W'(1);
      if (cnt_last) begin
        res_q <= {1'b0, root_d};
      end
    end
    if (out_write) begin
      out_cos_q  <= res_to_port(res_q);
      out_zero_q <= zero_q;
      out_ovf_q  <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_write) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o           = !out_valid_q;
  assign cosine_value_o    = out_cos_q;
  assign zero_magnitude_o  = out_zero_q;
  assign length_exceeded_o = out_ovf_q;

endmodule

[sv/cosine_similarity_engine.sv]
// Input: one element pair per cycle while full is low; full rises only
//   while two finished vectors wait in the job queue for the cosine unit.
// Path: last pair -> job queue -> multiply, compare, divide, root -> result
//   register -> empty low. A zero vector skips to the result register, a
//   clamped ratio skips divide and root; one vector at a time in the unit.
// Reset: rst_ni asynchronous, active low; clears sums and queue, sets empty.
module cosine_similarity_engine import csim_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request side
  input  logic               push,
  output logic               full,
  input  logic [COUNT_W-1:0] first_count_i,
  input  logic [COUNT_W-1:0] second_count_i,
  input  logic               last_element_i,
  // result side
  output logic               empty,
  input  logic               pop,
  output logic [COS_W-1:0]   cosine_value_o,
  output logic               zero_magnitude_o,
  output logic               length_exceeded_o
);

  // A request is taken whenever the job queue has room; the queue only
  // fills when the cosine unit lags by two whole vectors.
  logic      accept;
  csim_enq_t enq;
  logic      q_full, deq_valid, deq_ready;
  csim_job_t deq_job;

  assign accept = push & ~q_full;
  assign full   = q_full;

  // Front end: three 16x16 products and saturating 48-bit sums per pair.
  // The pair marked last is folded in and the totals go straight to the
  // queue, so the accumulators are clear for the next vector at once.
  csim_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .first_count_i  (first_count_i),
    .second_count_i (second_count_i),
    .last_element_i (last_element_i),
    .enq_o          (enq)
  );

  // Decouples the front end from the long cosine computation.
  csim_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enq_i       (enq),
    .full_o      (q_full),
    .deq_valid_o (deq_valid),
    .deq_job_o   (deq_job),
    .deq_ready_i (deq_ready)
  );

  // Back end: r = floor(sqrt(floor(dot^2 * 2^2F / (m1*m2)))), which is the
  // largest r with r^2*m1*m2 <= 2^2F*dot^2. dot^2 >= m1*m2 means the ratio
  // is at least one, so the result is clamped without dividing.
  csim_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_valid_i       (deq_valid),
    .job_i             (deq_job),
    .job_ready_o       (deq_ready),
    .pop_i             (pop),
    .empty_o           (empty),
    .cosine_value_o    (cosine_value_o),
    .zero_magnitude_o  (zero_magnitude_o),
    .length_exceeded_o (length_exceeded_o)
  );

endmodule

[sv/csim_checker.sv]
// Port-level checks for the cosine similarity engine, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module csim_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [16:0] cosine_value_o,
  input logic        zero_magnitude_o,
  input logic        length_exceeded_o
);

  // a zero vector always reports a zero cosine
  `CSIM_ASSERT_IMP(zero_gives_nil, !empty && zero_magnitude_o, cosine_value_o == 17'd0)

  // a waiting result stays put until it is taken
  `CSIM_ASSERT_NXT(result_held, !empty && !pop, !empty && $stable(cosine_value_o))

  // the job queue only fills on an accepted request
  `CSIM_ASSERT_NXT(full_on_push, !full && !push, !full)

  // while reset is held nothing is queued and no result shows
  `CSIM_ASSERT_ALW(reset_clear, !rst_ni, empty && !full)

endmodule

bind cosine_similarity_engine csim_checker u_csim_checker (.*);

[dv/cosine_similarity_engine_checker.sv]
// Scoreboard for the cosine similarity engine: watches both queue ports,
// predicts each vector's cosine and flags and compares them. Depends on csim_pkg.
module cosine_similarity_engine_checker import csim_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  logic [COUNT_W-1:0] first_count_i,
  input  logic [COUNT_W-1:0] second_count_i,
  input  logic               last_element_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic [COS_W-1:0]   cosine_value_i,
  input  logic               zero_magnitude_i,
  input  logic               length_exceeded_i,
  input  logic               drain_done_i,
  output int                 pending_o,
  output int                 fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] COUNT_MASK = (64'(1) << COUNT_BITS) - 64'(1);
  localparam logic [63:0] SUM_MAX    = (64'(1) << SUM_W) - 64'(1);

  typedef struct packed {
    logic [COS_W-1:0] cosine;
    logic             zero_mag;
    logic             len_exc;
  } cos_result_t;

  cos_result_t expected_cosines[$];

  sum_t               dot_acc, sq1_acc, sq2_acc;
  logic [TALLY_W-1:0] pair_tally;
  logic               past_limit;
  logic               leftovers_flagged;
  int                 fails = 0;
  int                 pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  task automatic report_mismatch(input string msg);
    $display("[%0t] cosine check: %s", $time, msg);
    fails++;
  endtask

  function automatic sum_t sat_add(input sum_t s, input logic [63:0] v);
    logic [63:0] t;
    t = 64'(s) + v;
    return (t > SUM_MAX) ? sum_t'(SUM_MAX) : t[SUM_W-1:0];
  endfunction

  // largest r with r*r*m1*m2 <= 2^(2F)*d*d, searched up to 2^F
  function automatic logic [COS_W-1:0] cosine_q(input sum_t d, input sum_t m1,
                                                input sum_t m2);
    logic [191:0] mag_prod, bound, lhs;
    logic [63:0]  lo, hi, mid;
    mag_prod = 192'(m1) * 192'(m2);
    bound    = (192'(d) * 192'(d)) << (2 * FRACTION_BITS);
    lo = '0;
    hi = 64'(1) << FRACTION_BITS;
    while (lo < hi) begin
      mid = lo + (hi - lo + 64'(1)) / 64'(2);
      lhs = mag_prod * (192'(mid) * 192'(mid));
      if (lhs <= bound) lo = mid;
      else hi = mid - 64'(1);
    end
    return lo[COS_W-1:0];
  endfunction

  task automatic clear_sums();
    dot_acc    = '0;
    sq1_acc    = '0;
    sq2_acc    = '0;
    pair_tally = '0;
    past_limit = 1'b0;
  endtask

  task automatic take_pair(input logic [COUNT_W-1:0] a_in, input logic [COUNT_W-1:0] b_in,
                           input logic is_last);
    logic [63:0] a, b;
    cos_result_t r;
    a = 64'(a_in) & COUNT_MASK;
    b = 64'(b_in) & COUNT_MASK;
    if (pair_tally >= TALLY_W'(MAX_ELEMENTS)) begin
      past_limit = 1'b1;
    end else begin
      dot_acc    = sat_add(dot_acc, a * b);
      sq1_acc    = sat_add(sq1_acc, a * a);
      sq2_acc    = sat_add(sq2_acc, b * b);
      pair_tally = pair_tally + TALLY_W'(1);
    end
    if (is_last) begin
      r.zero_mag = (sq1_acc == '0) || (sq2_acc == '0);
      r.cosine   = r.zero_mag ? '0 : cosine_q(dot_acc, sq1_acc, sq2_acc);
      r.len_exc  = past_limit;
      expected_cosines.insert(expected_cosines.size(), r);
      clear_sums();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cos_result_t want;
    if (!rst_ni) begin
      clear_sums();
      expected_cosines.delete();
      leftovers_flagged = 1'b0;
      pending <= 0;
    end else begin
      if (pop_i === 1'b1 && empty_i === 1'b0) begin
        if (expected_cosines.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", cosine_value_i));
        end else begin
          want = expected_cosines.pop_front();
          if (cosine_value_i !== want.cosine)
            report_mismatch($sformatf("cosine_value %0d, want %0d",
                                      cosine_value_i, want.cosine));
          if (zero_magnitude_i !== want.zero_mag)
            report_mismatch($sformatf("zero_magnitude %b, want %b",
                                      zero_magnitude_i, want.zero_mag));
          if (length_exceeded_i !== want.len_exc)
            report_mismatch($sformatf("length_exceeded %b, want %b",
                                      length_exceeded_i, want.len_exc));
        end
      end
      if (push_i === 1'b1 && full_i === 1'b0)
        take_pair(first_count_i, second_count_i, last_element_i);
      if (drain_done_i && !leftovers_flagged && expected_cosines.size() != 0) begin
        report_mismatch($sformatf("%0d results never arrived", expected_cosines.size()));
        leftovers_flagged = 1'b1;
      end
      pending <= expected_cosines.size();
    end
  end

endmodule

[dv/cosine_similarity_engine_tb.sv]
// Top of the cosine similarity engine testbench: clock, reset, request and
// result drivers, verdict. Depends on csim_pkg and the checker module.
module cosine_similarity_engine_tb import csim_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off to fill the job queue
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 60;    // idle tail, longer than one result's latency

  typedef enum logic [2:0] {
    MODE_RANDOM,
    MODE_SMALL,
    MODE_PARALLEL,
    MODE_ONE_ZERO,
    MODE_SPARSE,
    MODE_EXTREME
  } vec_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               push = 1'b0;
  logic               full;
  logic [COUNT_W-1:0] first_count = '0;
  logic [COUNT_W-1:0] second_count = '0;
  logic               last_element = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [COS_W-1:0]   cosine_value;
  logic               zero_magnitude;
  logic               length_exceeded;
  logic               drain_done = 1'b0;
  int                 pending;
  int                 fail_count;

  // shared between the two driver processes
  logic               quiet = 1'b0;       // no idling on either side
  logic               hold_toggle = 1'b0; // each flip asks the receiver for one long hold
  int                 random_sent = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  cosine_similarity_engine u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .first_count_i     (first_count),
    .second_count_i    (second_count),
    .last_element_i    (last_element),
    .empty             (empty),
    .pop               (pop),
    .cosine_value_o    (cosine_value),
    .zero_magnitude_o  (zero_magnitude),
    .length_exceeded_o (length_exceeded)
  );

  cosine_similarity_engine_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_i            (full),
    .first_count_i     (first_count),
    .second_count_i    (second_count),
    .last_element_i    (last_element),
    .empty_i           (empty),
    .pop_i             (pop),
    .cosine_value_i    (cosine_value),
    .zero_magnitude_i  (zero_magnitude),
    .length_exceeded_i (length_exceeded),
    .drain_done_i      (drain_done),
    .pending_o         (pending),
    .fail_count_o      (fail_count)
  );

  // Offer one request and wait for the edge that takes it. push stays high
  // on return, so back-to-back requests never drop it.
  task automatic send_pair(input logic [COUNT_W-1:0] a, input logic [COUNT_W-1:0] b,
                           input logic is_last);
    push         <= 1'b1;
    first_count  <= a;
    second_count <= b;
    last_element <= is_last;
    @(posedge clk_i);
    while (full !== 1'b0) @(posedge clk_i);
  endtask

  // Random idle burst on the request side; chance in percent.
  task automatic sender_gap(input int chance);
    if (!quiet && chance > 0 && $urandom_range(1, 100) <= chance) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // One whole vector pair. The mode shapes the content so that parallel,
  // orthogonal-ish, zero and extreme vectors all turn up.
  task automatic send_vector(input int len, input vec_mode_e mode, input int gap_chance,
                             input bit counts_random);
    logic [COUNT_W-1:0] a, b;
    int                 zero_side;
    zero_side = $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      a = COUNT_W'($urandom());
      b = COUNT_W'($urandom());
      case (mode)
        MODE_SMALL: begin
          a = COUNT_W'($urandom_range(0, 15));
          b = COUNT_W'($urandom_range(0, 15));
        end
        MODE_PARALLEL: b = a;
        MODE_ONE_ZERO: begin
          if (zero_side == 0) a = '0;
          else b = '0;
        end
        MODE_SPARSE: begin
          if ($urandom_range(0, 3) != 0) a = '0;
          if ($urandom_range(0, 3) != 0) b = '0;
        end
        MODE_EXTREME: begin
          a = $urandom_range(0, 1) ? '1 : '0;
          b = $urandom_range(0, 1) ? '1 : '0;
        end
        default: ;
      endcase
      sender_gap(gap_chance);
      send_pair(a, b, i == len - 1);
      if (counts_random) random_sent++;
    end
  endtask

  // Pause the request side until every predicted result has been taken.
  // The extra edge lets the checker count the request just accepted.
  task automatic wait_all_taken(input int limit);
    int waited;
    waited = 0;
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 && waited < limit) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // Result side: pops with random idle bursts in stretches, plus one long
  // hold whenever the stimulus flips hold_toggle.
  initial begin : result_side
    logic hold_seen;
    int   stall_pct;
    int   stretch;
    hold_seen = 1'b0;
    stall_pct = 0;
    stretch   = 0;
    @(posedge rst_ni);
    forever begin
      if (stretch == 0) begin
        stall_pct = $urandom_range(0, 1) ? 30 : 0;
        stretch   = $urandom_range(16, 96);
      end
      stretch--;
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!quiet && stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin : request_side
    int        len;
    int        pick;
    vec_mode_e mode;
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero vectors, full-scale and single-element pairs (cosine
    // exactly one), orthogonal vectors, bit patterns.
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1);
    send_pair(16'hFFFF, 16'h0000, 1'b1);
    send_pair(16'h0000, 16'h0001, 1'b1);
    send_pair(16'h0001, 16'hFFFF, 1'b1);
    send_pair(16'hFFFF, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'hFFFF, 1'b1);
    send_pair(16'd3, 16'd4, 1'b0);
    send_pair(16'd4, 16'd3, 1'b1);
    send_pair(16'hFFFF, 16'h0001, 1'b0);
    send_pair(16'h0001, 16'hFFFF, 1'b0);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1);
    send_pair(16'hAAAA, 16'h5555, 1'b0);
    send_pair(16'h5555, 16'hAAAA, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b0);
    send_pair(16'h8000, 16'h8000, 1'b0);
    send_pair(16'h0000, 16'h0000, 1'b1);

    // Back-pressure: receiver holds off while short vectors keep coming,
    // so the job queue fills and full stalls the requests.
    hold_toggle <= ~hold_toggle;
    repeat (8) send_vector(2, MODE_RANDOM, 0, 1'b0);
    wait_all_taken(DRAIN_LIMIT);

    // Random vectors, mostly short, a few longer ones.
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) len = $urandom_range(1, 8);
      else if (pick < 95) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 120);
      mode = vec_mode_e'($urandom_range(0, 5));
      send_vector(len, mode, $urandom_range(0, 1) ? 35 : 0, 1'b1);
    end

    // Sender pause until everything has come back.
    wait_all_taken(DRAIN_LIMIT);

    // Final part without idling: short vectors back to back.
    quiet <= 1'b1;
    repeat (6) begin
      len  = $urandom_range(1, 8);
      mode = vec_mode_e'($urandom_range(0, 5));
      send_vector(len, mode, 0, 1'b0);
    end

    wait_all_taken(DRAIN_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin : watchdog
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
